// ----- rtl/bmp_pkg.sv -----
// shared constants, codes and types for the bone matrix palette
package bmp_pkg;

  localparam int MAX_BONES = 64;
  localparam int BONE_W    = $clog2(MAX_BONES);
  localparam int ELEM_AW   = BONE_W + 4;
  localparam int ELEMS     = MAX_BONES * 16;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int PAR_W     = 7;
  localparam int CNT_W     = 7;

  typedef enum logic [2:0] {
    REQ_WR_LOCAL  = 3'd0,
    REQ_WR_OFFSET = 3'd1,
    REQ_SET_PAR   = 3'd2,
    REQ_COMPUTE   = 3'd3,
    REQ_READ      = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_READ = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAR,
    S_CHK,
    S_MUL,
    S_WAIT,
    S_RD
  } state_t;

  // tag that travels with each operand pair through the mac
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [3:0] elem;
  } mac_tag_t;

endpackage

// ----- rtl/bone_matrix_palette_top.sv -----
// bone matrix palette: element stores, parent table, compute sequencer
//
// Input channel (in_valid/in_stall) takes one request per transfer: local or
// offset element writes, parent sets, compute and read. Results leave on the
// out_valid/out_stall channel through an output register: one result for a
// read or a compute, none for the other requests.
// Writes and parent sets are stored as they are accepted. A read fetches the
// element from the final store into a register and hands it to the output
// register in state S_RD. A compute walks bone_count bones (capped at 64);
// each bone does a parent check (S_PAR, S_CHK) and two 4x4 matrix products
// on the single shared multiplier, each of 64 multiply steps and a drain.
// The block takes no request while a compute or read is underway.
// Root bones multiply by identity, so every product goes through the same
// floor shift and saturation path.
// Synchronous reset marks every parent as root and sets bone_count to 1;
// the element stores hold nothing meaningful until written.
// A stalled result holds on the output and keeps new requests out.
module bone_matrix_palette_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bmp_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_req_type,
  input  logic [5:0]                        in_bone_index,
  input  logic [3:0]                        in_element_index,
  input  logic signed [31:0]                in_elem_value,
  input  logic signed [6:0]                 in_parent_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [5:0]                        out_bone,
  output logic [3:0]                        out_element,
  output logic signed [31:0]                out_value
);

  bmp_pkg::state_t state_r, state_nxt;

  logic [bmp_pkg::VAL_W-1:0]  local_mem  [bmp_pkg::ELEMS];
  logic [bmp_pkg::VAL_W-1:0]  offset_mem [bmp_pkg::ELEMS];
  logic [bmp_pkg::VAL_W-1:0]  comb_mem   [bmp_pkg::ELEMS];
  logic [bmp_pkg::VAL_W-1:0]  final_mem  [bmp_pkg::ELEMS];
  logic [bmp_pkg::PAR_W-1:0]  par_mem    [bmp_pkg::MAX_BONES];
  logic [bmp_pkg::MAX_BONES-1:0] par_vld_r;

  logic [bmp_pkg::CNT_W-1:0]  bone_count_r;
  logic [bmp_pkg::CNT_W-1:0]  lim;
  logic [bmp_pkg::BONE_W-1:0] bone_r;
  logic [bmp_pkg::BONE_W-1:0] par_r;
  logic                       root_r;
  logic                       phase_r;
  logic [5:0]                 cnt_r;

  logic [bmp_pkg::VAL_W-1:0]  local_q, offset_q, comb_q, final_q;
  logic [bmp_pkg::PAR_W-1:0]  par_q;
  logic                       par_vq;
  logic [3:0]                 a_el, b_el;
  logic [bmp_pkg::ELEM_AW-1:0] in_addr;

  bmp_pkg::mac_tag_t          tag_r;
  logic [1:0]                 tag_k_r;
  logic signed [bmp_pkg::VAL_W-1:0] op_a, op_b;
  logic                       mac_busy, res_vld;
  logic [3:0]                 res_elem;
  logic signed [bmp_pkg::VAL_W-1:0] res_value;

  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [5:0]                 out_bone_r;
  logic [3:0]                 out_element_r;
  logic [31:0]                out_value_r;
  logic [5:0]                 rd_bone_r;
  logic [3:0]                 rd_el_r;

  logic in_fire, busy, last_bone, bad_par, issue;
  logic set_done, set_fail, set_read, start_bone, next_bone, start_mul, next_phase;

  assign in_stall  = (state_r != bmp_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign in_addr   = {in_bone_index, in_element_index};
  assign lim       = (bone_count_r > bmp_pkg::CNT_W'(bmp_pkg::MAX_BONES)) ?
                     bmp_pkg::CNT_W'(bmp_pkg::MAX_BONES) : bone_count_r;
  assign last_bone = (bmp_pkg::CNT_W'(bone_r) + bmp_pkg::CNT_W'(1)) == lim;
  assign busy      = tag_r.vld || mac_busy;
  // parent must come earlier in the walk unless it is a root
  assign bad_par   = par_vq && !par_q[bmp_pkg::PAR_W-1] &&
                     (par_q[bmp_pkg::BONE_W-1:0] >= bone_r);

  // step order is row, column, then k innermost
  assign a_el = {cnt_r[5:4], cnt_r[1:0]};
  assign b_el = {cnt_r[1:0], cnt_r[3:2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    set_done   = 1'b0;
    set_fail   = 1'b0;
    set_read   = 1'b0;
    start_bone = 1'b0;
    next_bone  = 1'b0;
    start_mul  = 1'b0;
    next_phase = 1'b0;
    issue      = 1'b0;
    unique case (state_r)
      bmp_pkg::S_IDLE: begin
        if (in_fire && in_req_type == bmp_pkg::REQ_COMPUTE) begin
          if (lim == '0) begin
            set_done = 1'b1;
          end else begin
            start_bone = 1'b1;
            state_nxt  = bmp_pkg::S_PAR;
          end
        end else if (in_fire && in_req_type == bmp_pkg::REQ_READ) begin
          state_nxt = bmp_pkg::S_RD;
        end
      end
      bmp_pkg::S_PAR: begin
        state_nxt = bmp_pkg::S_CHK;
      end
      bmp_pkg::S_CHK: begin
        if (bad_par) begin
          set_fail  = 1'b1;
          state_nxt = bmp_pkg::S_IDLE;
        end else begin
          start_mul = 1'b1;
          state_nxt = bmp_pkg::S_MUL;
        end
      end
      bmp_pkg::S_MUL: begin
        issue = 1'b1;
        if (cnt_r == '1) begin
          state_nxt = bmp_pkg::S_WAIT;
        end
      end
      bmp_pkg::S_WAIT: begin
        if (!busy) begin
          if (!phase_r) begin
            next_phase = 1'b1;
            state_nxt  = bmp_pkg::S_MUL;
          end else if (last_bone) begin
            set_done  = 1'b1;
            state_nxt = bmp_pkg::S_IDLE;
          end else begin
            next_bone = 1'b1;
            state_nxt = bmp_pkg::S_PAR;
          end
        end
      end
      bmp_pkg::S_RD: begin
        set_read  = 1'b1;
        state_nxt = bmp_pkg::S_IDLE;
      end
      default: state_nxt = bmp_pkg::S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (start_bone) begin
      bone_r <= '0;
    end else if (next_bone) begin
      bone_r <= bone_r + 1'b1;
    end
    if (start_mul) begin
      par_r   <= par_q[bmp_pkg::BONE_W-1:0];
      root_r  <= !par_vq || par_q[bmp_pkg::PAR_W-1];
      phase_r <= 1'b0;
    end else if (next_phase) begin
      phase_r <= 1'b1;
    end
    if (start_mul || next_phase) begin
      cnt_r <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
    tag_k_r <= cnt_r[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= issue;
    end
    tag_r.elem  <= {cnt_r[5:4], cnt_r[3:2]};
    tag_r.first <= cnt_r[1:0] == 2'd0;
    tag_r.last  <= cnt_r[1:0] == 2'd3;
  end

  // element stores
  always_ff @(posedge clk) begin
    if (in_fire && in_req_type == bmp_pkg::REQ_WR_LOCAL) begin
      local_mem[in_addr] <= in_elem_value;
    end
    if (in_fire && in_req_type == bmp_pkg::REQ_WR_OFFSET) begin
      offset_mem[in_addr] <= in_elem_value;
    end
    if (res_vld && !phase_r) begin
      comb_mem[{bone_r, res_elem}] <= res_value;
    end
    if (res_vld && phase_r) begin
      final_mem[{bone_r, res_elem}] <= res_value;
    end
    if (in_fire && in_req_type == bmp_pkg::REQ_SET_PAR) begin
      par_mem[in_bone_index] <= in_parent_index;
    end
    local_q  <= local_mem[{bone_r, a_el}];
    offset_q <= offset_mem[{bone_r, a_el}];
    comb_q   <= comb_mem[{(phase_r ? bone_r : par_r), b_el}];
    final_q  <= final_mem[in_addr];
    par_q    <= par_mem[bone_r];
    par_vq   <= par_vld_r[bone_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_vld_r <= '0;
    end else if (in_fire && in_req_type == bmp_pkg::REQ_SET_PAR) begin
      par_vld_r[in_bone_index] <= 1'b1;
    end
  end

  // operand select; a root multiplies by identity
  always_comb begin
    op_a = phase_r ? offset_q : local_q;
    if (!phase_r && root_r) begin
      op_b = (tag_k_r == tag_r.elem[1:0]) ?
             (bmp_pkg::VAL_W'(1) << bmp_pkg::FRAC_BITS) : '0;
    end else begin
      op_b = comb_q;
    end
  end

  bmp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag_r),
    .op_a      (op_a),
    .op_b      (op_b),
    .busy      (mac_busy),
    .res_vld   (res_vld),
    .res_elem  (res_elem),
    .res_value (res_value)
  );

  // configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= bmp_pkg::CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bone_count_r <= cfg_wr_data;
      end
      if (set_done || set_fail || set_read) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_bone_r <= in_bone_index;
      rd_el_r   <= in_element_index;
    end
    if (set_read) begin
      out_status_r  <= bmp_pkg::ST_READ;
      out_bone_r    <= rd_bone_r;
      out_element_r <= rd_el_r;
      out_value_r   <= final_q;
    end else if (set_fail) begin
      out_status_r  <= bmp_pkg::ST_FAIL;
      out_bone_r    <= bone_r;
      out_element_r <= '0;
      out_value_r   <= '0;
    end else if (set_done) begin
      out_status_r  <= bmp_pkg::ST_DONE;
      out_bone_r    <= '0;
      out_element_r <= '0;
      out_value_r   <= '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_bone    = out_bone_r;
  assign out_element = out_element_r;
  assign out_value   = out_value_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == bmp_pkg::S_IDLE)
    else $error("transfer accepted while sequencer busy");

  a_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (state_r == bmp_pkg::S_MUL || state_r == bmp_pkg::S_WAIT))
    else $error("mac result outside a product pass");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmp_pkg::S_IDLE && !out_valid_r) |-> !in_stall)
    else $error("idle block stalls input");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (set_done || set_fail || set_read) |-> !(out_valid_r && out_stall))
    else $error("result written over a pending transfer");

endmodule

// ----- rtl/bmp_mac.sv -----
// shared multiply-accumulate unit with floor shift and saturation
module bmp_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bmp_pkg::mac_tag_t                  tag,
  input  logic signed [bmp_pkg::VAL_W-1:0]   op_a,
  input  logic signed [bmp_pkg::VAL_W-1:0]   op_b,
  output logic                               busy,
  output logic                               res_vld,
  output logic [3:0]                         res_elem,
  output logic signed [bmp_pkg::VAL_W-1:0]   res_value
);

  localparam logic signed [bmp_pkg::ACC_W-1:0] SMAX =
    {{(bmp_pkg::ACC_W-bmp_pkg::VAL_W+1){1'b0}}, {(bmp_pkg::VAL_W-1){1'b1}}};
  localparam logic signed [bmp_pkg::ACC_W-1:0] SMIN =
    {{(bmp_pkg::ACC_W-bmp_pkg::VAL_W+1){1'b1}}, {(bmp_pkg::VAL_W-1){1'b0}}};

  bmp_pkg::mac_tag_t                   p_tag_r;
  logic signed [bmp_pkg::PROD_W-1:0]   prod_r;
  logic signed [bmp_pkg::ACC_W-1:0]    acc_r;
  logic signed [bmp_pkg::ACC_W-1:0]    acc_nxt;
  logic signed [bmp_pkg::ACC_W-1:0]    prod_ext;
  logic signed [bmp_pkg::ACC_W-1:0]    shifted;
  logic                                res_vld_r;
  logic [3:0]                          res_elem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_tag_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      p_tag_r   <= tag;
      res_vld_r <= p_tag_r.vld && p_tag_r.last;
    end
  end

  assign prod_ext = bmp_pkg::ACC_W'(prod_r);
  assign acc_nxt  = p_tag_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (p_tag_r.vld) begin
      acc_r <= acc_nxt;
    end
    res_elem_r <= p_tag_r.elem;
  end

  // the exact sum is shifted down once; products are not floored one by one
  assign shifted = acc_r >>> bmp_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > SMAX) begin
      res_value = SMAX[bmp_pkg::VAL_W-1:0];
    end else if (shifted < SMIN) begin
      res_value = SMIN[bmp_pkg::VAL_W-1:0];
    end else begin
      res_value = shifted[bmp_pkg::VAL_W-1:0];
    end
  end

  assign res_vld  = res_vld_r;
  assign res_elem = res_elem_r;
  assign busy     = p_tag_r.vld || res_vld_r;

endmodule

// ----- verif/testbench.sv -----
// testbench for the bone matrix palette: directed, extreme-count and random request streams
module testbench;

  localparam int WDOG_LIMIT = 60000;
  localparam int IDLE_PCT   = 22;

  typedef logic signed [31:0] mat_t [16];

  typedef struct {
    bmp_pkg::status_t   status;
    logic [5:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] value;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [bmp_pkg::CNT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [5:0] in_bone_index = '0;
  logic [3:0] in_element_index = '0;
  logic signed [31:0] in_elem_value = '0;
  logic signed [6:0] in_parent_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_bone;
  logic [3:0] out_element;
  logic signed [31:0] out_value;

  bone_matrix_palette_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_bone_index(in_bone_index),
    .in_element_index(in_element_index), .in_elem_value(in_elem_value),
    .in_parent_index(in_parent_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_bone(out_bone),
    .out_element(out_element), .out_value(out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the palette
  logic signed [31:0] local_m [bmp_pkg::ELEMS];
  logic signed [31:0] offset_m [bmp_pkg::ELEMS];
  logic signed [31:0] combined_m [bmp_pkg::ELEMS];
  logic signed [31:0] final_m [bmp_pkg::ELEMS];
  logic signed [6:0]  parent_tbl [bmp_pkg::MAX_BONES];
  bit                 local_wr [bmp_pkg::ELEMS];
  bit                 offset_wr [bmp_pkg::ELEMS];
  bit                 final_ok [bmp_pkg::MAX_BONES];
  logic [bmp_pkg::CNT_W-1:0] bone_cnt;

  result_t pending_q [$];
  int      errors = 0;
  bit      no_idle = 1'b0;
  int      quiet_cycles = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic signed [31:0] dot4(input mat_t a, input mat_t b, input int r,
                                              input int c);
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    acc = '0;
    for (int k = 0; k < 4; k++)
      acc += 66'(a[r*4+k]) * 66'(b[k*4+c]);
    sh = acc >>> bmp_pkg::FRAC_BITS;
    if (sh > 66'sd2147483647) return 32'sh7fffffff;
    if (sh < -66'sd2147483648) return 32'sh80000000;
    return sh[31:0];
  endfunction

  function automatic void mat_mul(input mat_t a, input mat_t b, output mat_t c);
    for (int r = 0; r < 4; r++)
      for (int col = 0; col < 4; col++)
        c[r*4+col] = dot4(a, b, r, col);
  endfunction

  // walks the bones as the block does and returns the expected status
  function automatic result_t palette_compute();
    result_t res;
    int n;
    mat_t lm, om, pm, cm, fm;
    res = '{bmp_pkg::ST_DONE, 6'd0, 4'd0, 32'sd0};
    n = (bone_cnt > bmp_pkg::MAX_BONES) ? bmp_pkg::MAX_BONES : bone_cnt;
    for (int b = 0; b < n; b++) begin
      if (parent_tbl[b] >= 0 && parent_tbl[b] >= b) begin
        res.status = bmp_pkg::ST_FAIL;
        res.bone = b[5:0];
        return res;
      end
      for (int e = 0; e < 16; e++) begin
        lm[e] = local_m[b*16+e];
        om[e] = offset_m[b*16+e];
        if (parent_tbl[b] >= 0) pm[e] = combined_m[parent_tbl[b]*16+e];
      end
      if (parent_tbl[b] < 0) cm = lm;
      else mat_mul(lm, pm, cm);
      mat_mul(om, cm, fm);
      for (int e = 0; e < 16; e++) begin
        combined_m[b*16+e] = cm[e];
        final_m[b*16+e] = fm[e];
      end
      final_ok[b] = 1'b1;
    end
    return res;
  endfunction

  function automatic void predict(input logic [2:0] rq, input logic [5:0] bone,
                                  input logic [3:0] el, input logic signed [31:0] val,
                                  input logic signed [6:0] par);
    int addr;
    addr = bone * 16 + el;
    case (rq)
      bmp_pkg::REQ_WR_LOCAL: begin
        local_m[addr] = val;
        local_wr[addr] = 1'b1;
      end
      bmp_pkg::REQ_WR_OFFSET: begin
        offset_m[addr] = val;
        offset_wr[addr] = 1'b1;
      end
      bmp_pkg::REQ_SET_PAR: parent_tbl[bone] = par;
      bmp_pkg::REQ_COMPUTE: pending_q.push_back(palette_compute());
      bmp_pkg::REQ_READ: pending_q.push_back('{bmp_pkg::ST_READ, bone, el, final_m[addr]});
      default: ;
    endcase
  endfunction

  function automatic bit bone_loaded(input int b);
    for (int e = 0; e < 16; e++)
      if (!local_wr[b*16+e] || !offset_wr[b*16+e]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [2:0] rq, input logic [5:0] bone,
                           input logic [3:0] el, input logic signed [31:0] val,
                           input logic signed [6:0] par);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_bone_index <= bone;
    in_element_index <= el;
    in_elem_value <= val;
    in_parent_index <= par;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(rq, bone, el, val, par);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      3: return 32'sh00010000;
      default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic logic signed [6:0] pick_parent(input int bone);
    if (bone > 0 && $urandom_range(3) != 0) return $urandom_range(0, bone - 1);
    if ($urandom_range(1)) return -$signed(7'($urandom_range(1, 64)));
    return $urandom_range(0, 63);
  endfunction

  task automatic load_bone(input int b);
    for (int e = 0; e < 16; e++) begin
      send_item(bmp_pkg::REQ_WR_LOCAL, b, e, pick_value(), $urandom);
      send_item(bmp_pkg::REQ_WR_OFFSET, b, e, pick_value(), $urandom);
    end
  endtask

  // a compute must never touch unwritten matrices: cut the walk at the first unloaded bone
  task automatic send_compute();
    int n;
    n = (bone_cnt > bmp_pkg::MAX_BONES) ? bmp_pkg::MAX_BONES : bone_cnt;
    for (int b = 0; b < n; b++) begin
      if (parent_tbl[b] >= 0 && parent_tbl[b] >= b) break;
      if (!bone_loaded(b)) begin
        send_item(bmp_pkg::REQ_SET_PAR, b, $urandom, $urandom, 7'(b));
        break;
      end
    end
    send_item(bmp_pkg::REQ_COMPUTE, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_read();
    int b;
    b = $urandom_range(0, 63);
    for (int i = 0; i < 64 && !final_ok[b]; i++) b = (b + 1) % 64;
    if (final_ok[b]) send_item(bmp_pkg::REQ_READ, b, $urandom, $urandom, $urandom);
  endtask

  // block idle: nothing owed, and any write in flight settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_bone_count(input logic [bmp_pkg::CNT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bone_cnt = v;
  endtask

  task automatic test_directed();
    for (int e = 0; e < 16; e++) begin
      send_item(bmp_pkg::REQ_WR_LOCAL, 0, e,
                (e % 5 == 0) ? 32'sh7fffffff : 32'sh80000000, -7'sd1);
      send_item(bmp_pkg::REQ_WR_OFFSET, 0, e,
                (e % 5 == 0) ? 32'sh00010000 : 32'sd0, 7'sd63);
      send_item(bmp_pkg::REQ_WR_LOCAL, 1, e, 32'sh80000000, 7'sd0);
      send_item(bmp_pkg::REQ_WR_OFFSET, 1, e, 32'sh7fffffff, 7'sd0);
    end
    send_item(bmp_pkg::REQ_SET_PAR, 1, 0, 0, 7'sd0);
    set_bone_count(2);
    send_compute();
    send_item(bmp_pkg::REQ_READ, 0, 0, 0, 0);
    send_item(bmp_pkg::REQ_READ, 1, 15, 0, 0);
    send_item(bmp_pkg::REQ_READ, 1, 5, 0, 0);
    for (int rq = 5; rq < 8; rq++) send_item(rq, 63, 15, 32'shffffffff, 7'sd63);
    send_item(bmp_pkg::REQ_SET_PAR, 1, 0, 0, 7'sd1);
    send_compute();
    send_item(bmp_pkg::REQ_SET_PAR, 1, 0, 0, -7'sd64);
    send_compute();
    set_bone_count(0);
    send_compute();
    set_bone_count(127);
    send_compute();
    send_item(bmp_pkg::REQ_READ, 1, 3, 0, 0);
  endtask

  task automatic test_count_extremes();
    for (int b = 2; b < 5; b++) load_bone(b);
    send_item(bmp_pkg::REQ_SET_PAR, 2, 0, 0, 7'sd0);
    send_item(bmp_pkg::REQ_SET_PAR, 3, 0, 0, 7'sd2);
    send_item(bmp_pkg::REQ_SET_PAR, 4, 0, 0, 7'sd1);
    set_bone_count(64);
    send_compute();
    send_read();
    set_bone_count(1);
    send_compute();
    send_read();
  endtask

  task automatic test_random();
    int k;
    for (int seg = 0; seg < 10; seg++) begin
      no_idle = (seg == 3);
      case ($urandom_range(7))
        0: set_bone_count($urandom_range(0, 127));
        1: set_bone_count(64);
        default: set_bone_count($urandom_range(1, 8));
      endcase
      for (int i = 0; i < 100; i++) begin
        k = $urandom_range(99);
        if (k < 45) begin
          automatic int b = ($urandom_range(9) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 9);
          send_item(k[0] ? bmp_pkg::REQ_WR_LOCAL : bmp_pkg::REQ_WR_OFFSET, b, $urandom,
                    pick_value(), $urandom);
        end else if (k < 57) begin
          automatic int b = ($urandom_range(4) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 9);
          send_item(bmp_pkg::REQ_SET_PAR, b, $urandom, $urandom, pick_parent(b));
        end else if (k < 90) begin
          send_read();
        end else if (k < 96) begin
          send_compute();
        end else begin
          send_item($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && $urandom_range(99) < IDLE_PCT && !no_idle) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result status %0d bone %0d", out_status, out_bone));
      end else begin
        automatic result_t want = pending_q.pop_front();
        if (out_status !== want.status || out_bone !== want.bone ||
            out_element !== want.elem || out_value !== want.value)
          report($sformatf("got st %0d bone %0d el %0d val %h, want %0d %0d %0d %h",
                           out_status, out_bone, out_element, out_value,
                           want.status, want.bone, want.elem, want.value));
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("bone_matrix_palette_top test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < bmp_pkg::ELEMS; i++) begin
      local_m[i] = '0; offset_m[i] = '0; combined_m[i] = '0; final_m[i] = '0;
      local_wr[i] = 1'b0; offset_wr[i] = 1'b0;
    end
    for (int b = 0; b < bmp_pkg::MAX_BONES; b++) begin
      parent_tbl[b] = -7'sd1;
      final_ok[b] = 1'b0;
    end
    bone_cnt = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_count_extremes();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("bone_matrix_palette_top test passed");
    end else begin
      $display("bone_matrix_palette_top test failed");
    end
    $finish;
  end

endmodule

// ----- bone_matrix_palette_top.f -----
rtl/bmp_pkg.sv
rtl/bmp_mac.sv
rtl/bone_matrix_palette_top.sv
verif/testbench.sv
